[hw/rtl/fgsa_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package fgsa_pkg;
  localparam int unsigned PoolSlotsDefault = 256;
  localparam int unsigned AlignBytes = 256;

  localparam logic [1:0] CmdAcquire = 2'd0;
  localparam logic [1:0] CmdRelease = 2'd1;
  localparam logic [1:0] CmdReclaim = 2'd2;
  localparam logic [1:0] CmdQuery   = 2'd3;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StExhaust  = 2'd1;
  localparam logic [1:0] StBadIndex = 2'd2;
  localparam logic [1:0] StPendFull = 2'd3;

  localparam logic [1:0] RegBase   = 2'd0;
  localparam logic [1:0] RegVertex = 2'd1;
  localparam logic [1:0] RegIndex  = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [9:0]  slot_index;
    logic [63:0] fence;
    logic        bad_index;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  granted_slot;
    logic [63:0] vtx_addr;
    logic [63:0] idx_addr;
    logic [8:0]  reclaimed_count;
    logic [8:0]  free_slots;
  } res_t;
endpackage
`default_nettype wire

[hw/rtl/fgsa_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module fgsa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256,
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [Width-1:0] rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

[hw/rtl/fgsa_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module fgsa_front #(
  parameter int unsigned PoolSlots = fgsa_pkg::PoolSlotsDefault
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  output logic                ready_o,
  input  wire logic [1:0]     command_i,
  input  wire logic [9:0]     slot_index_i,
  input  wire logic [63:0]    fence_i,
  output logic                valid_o,
  input  wire logic           ready_i,
  output fgsa_pkg::cmd_t      cmd_o
);
  // two-entry queue
  fgsa_pkg::cmd_t q_q [2];
  logic rd_q, wr_q;
  logic [1:0] cnt_q;
  logic push, pop;
  fgsa_pkg::cmd_t in_c;

  always_comb begin
    in_c.command    = command_i;
    in_c.slot_index = slot_index_i;
    in_c.fence      = fence_i;
    in_c.bad_index  = ({22'd0, slot_index_i} >= 32'(PoolSlots));
  end

  assign ready_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign push = valid_i && ready_o;
  assign pop  = valid_o && ready_i;
  assign cmd_o = q_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wr_q] <= in_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= 1'b0;
      wr_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("queue count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0) |-> !pop) else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2) |-> !push) else $error("push into full queue");
endmodule
`default_nettype wire

[hw/rtl/fgsa_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module fgsa_back #(
  parameter int unsigned PoolSlots = fgsa_pkg::PoolSlotsDefault,
  localparam int unsigned SW = $clog2(PoolSlots),
  localparam int unsigned DW = $clog2(PoolSlots + 1)
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  output logic                ready_o,
  input  wire fgsa_pkg::cmd_t cmd_i,
  input  wire logic [63:0]    base_i,
  input  wire logic [31:0]    vblk_i,
  input  wire logic [31:0]    iblk_i,
  output logic                valid_o,
  input  wire logic           ready_i,
  output fgsa_pkg::res_t      res_o
);
  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SInit  = 3'd1;
  localparam logic [2:0] SPop   = 3'd2;
  localparam logic [2:0] SWalk  = 3'd3;
  localparam logic [2:0] SMul   = 3'd4;
  localparam logic [2:0] SMul2  = 3'd5;
  localparam logic [2:0] SOut   = 3'd6;

  logic [2:0] st_q, st_d;
  logic [DW-1:0] fdep_q, fdep_d, pdep_q, pdep_d;
  logic [DW-1:0] r_q, r_d, w_q, w_d, rc_q, rc_d;
  fgsa_pkg::cmd_t c_q, c_d;
  fgsa_pkg::res_t res_q, res_d;
  logic ov_q, ov_d;
  logic [63:0] acc_q, acc_d, strd_q, strd_d, vb_q, vb_d;

  // memories
  logic fs_we, ps_we, pf_we;
  logic [SW-1:0] fs_wa, fs_ra, pw_a, pr_a;
  logic [SW-1:0] fs_wd, fs_rd, ps_wd, ps_rd;
  logic [63:0] pf_wd, pf_rd;

  fgsa_ram #(.Width(SW), .Depth(PoolSlots)) u_free (
    .clk_i, .we_i(fs_we), .waddr_i(fs_wa), .wdata_i(fs_wd),
    .raddr_i(fs_ra), .rdata_o(fs_rd));
  fgsa_ram #(.Width(SW), .Depth(PoolSlots)) u_pslot (
    .clk_i, .we_i(ps_we), .waddr_i(pw_a), .wdata_i(ps_wd),
    .raddr_i(pr_a), .rdata_o(ps_rd));
  fgsa_ram #(.Width(64), .Depth(PoolSlots)) u_pfence (
    .clk_i, .we_i(pf_we), .waddr_i(pw_a), .wdata_i(pf_wd),
    .raddr_i(pr_a), .rdata_o(pf_rd));

  assign ready_o = (st_q == SIdle) && !ov_q;
  assign valid_o = ov_q;
  assign res_o = res_q;

  logic [63:0] va, vbl, ibl;
  always_comb begin
    st_d = st_q; fdep_d = fdep_q; pdep_d = pdep_q; r_d = r_q; w_d = w_q;
    rc_d = rc_q; c_d = c_q; res_d = res_q; ov_d = ov_q;
    acc_d = acc_q; strd_d = strd_q; vb_d = vb_q;
    fs_we = 1'b0; fs_wa = fdep_q[SW-1:0]; fs_wd = ps_rd;
    fs_ra = fdep_q[SW-1:0] - SW'(1);
    ps_we = 1'b0; pf_we = 1'b0; pw_a = pdep_q[SW-1:0];
    ps_wd = c_q.slot_index[SW-1:0]; pf_wd = c_q.fence;
    pr_a = r_q[SW-1:0];
    vbl = ({32'd0, vblk_i} + 64'(fgsa_pkg::AlignBytes - 1)) & ~64'(fgsa_pkg::AlignBytes - 1);
    ibl = ({32'd0, iblk_i} + 64'(fgsa_pkg::AlignBytes - 1)) & ~64'(fgsa_pkg::AlignBytes - 1);
    va = acc_q + base_i;
    if (ov_q && ready_i) ov_d = 1'b0;
    case (st_q)
      SInit: begin
        fs_we = 1'b1; fs_wa = r_q[SW-1:0];
        fs_wd = SW'(PoolSlots - 1) - r_q[SW-1:0];
        r_d = r_q + DW'(1);
        if (r_q == DW'(PoolSlots - 1)) st_d = SIdle;
      end
      SIdle: begin
        if (valid_i && ready_o) begin
          c_d = cmd_i;
          res_d = '0;
          r_d = '0; w_d = '0; rc_d = '0;
          case (cmd_i.command)
            fgsa_pkg::CmdAcquire: begin
              if (fdep_q == '0) begin
                res_d.status = fgsa_pkg::StExhaust;
                st_d = SOut;
              end else st_d = SPop;
            end
            fgsa_pkg::CmdRelease: begin
              if (cmd_i.bad_index) res_d.status = fgsa_pkg::StBadIndex;
              else if (pdep_q == DW'(PoolSlots)) res_d.status = fgsa_pkg::StPendFull;
              else begin
                ps_we = 1'b1; pf_we = 1'b1;
                ps_wd = cmd_i.slot_index[SW-1:0]; pf_wd = cmd_i.fence;
                pdep_d = pdep_q + DW'(1);
              end
              st_d = SOut;
            end
            fgsa_pkg::CmdReclaim: begin
              pr_a = '0;
              st_d = (pdep_q == '0) ? SOut : SWalk;
              if (pdep_q == '0) pdep_d = '0;
            end
            default: begin
              if (cmd_i.bad_index) begin
                res_d.status = fgsa_pkg::StBadIndex; st_d = SOut;
              end else begin
                strd_d = vbl + ibl; vb_d = vbl; st_d = SMul;
              end
            end
          endcase
        end
      end
      SPop: begin
        fdep_d = fdep_q - DW'(1);
        res_d.granted_slot = 8'(fs_rd);
        st_d = SOut;
      end
      SWalk: begin
        // r_q entry data is valid now; prefetch next
        pr_a = SW'(r_q + DW'(1));
        if (pf_rd <= c_q.fence) begin
          if (fdep_q != DW'(PoolSlots)) begin
            fs_we = 1'b1;
            fdep_d = fdep_q + DW'(1);
            rc_d = rc_q + DW'(1);
          end
        end else begin
          ps_we = 1'b1; pf_we = 1'b1; pw_a = w_q[SW-1:0];
          ps_wd = ps_rd; pf_wd = pf_rd;
          w_d = w_q + DW'(1);
        end
        r_d = r_q + DW'(1);
        if (r_q + DW'(1) == pdep_q) begin
          pdep_d = (pf_rd <= c_q.fence) ? w_q : w_q + DW'(1);
          st_d = SOut;
        end
      end
      SMul: begin
        acc_d = 64'(c_q.slot_index) * strd_q;
        st_d = SMul2;
      end
      SMul2: begin
        res_d.vtx_addr = va;
        res_d.idx_addr = va + vb_q;
        st_d = SOut;
      end
      SOut: begin
        res_d.reclaimed_count = 9'(rc_q);
        res_d.free_slots = 9'(fdep_q);
        ov_d = 1'b1;
        st_d = SIdle;
      end
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    c_q <= c_d; res_q <= res_d; acc_q <= acc_d; strd_q <= strd_d; vb_q <= vb_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SInit; fdep_q <= DW'(PoolSlots); pdep_q <= '0;
      r_q <= '0; w_q <= '0; rc_q <= '0; ov_q <= 1'b0;
    end else begin
      st_q <= st_d; fdep_q <= fdep_d; pdep_q <= pdep_d;
      r_q <= r_d; w_q <= w_d; rc_q <= rc_d; ov_q <= ov_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) fdep_q <= DW'(PoolSlots))
    else $error("free depth beyond pool");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pdep_q <= DW'(PoolSlots))
    else $error("pending depth beyond pool");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == SWalk) |-> (w_q <= r_q)) else $error("compaction overtook walk");
endmodule
`default_nettype wire

[hw/rtl/fence_gated_slot_allocator_top.sv]
// channel  | dir | tdata fields (low bit up)                       | tuser
// s_axis   | in  | command[1:0] slot_index[11:2] fence[75:12]      | -
// m_axis   | out | status, granted_slot, vtx_addr,
//          |     | idx_addr, reclaimed_count, free_slots           | -
// cfg      | in  | cfg_we_i, cfg_idx_i (0 base, 1 vertex, 2 index), cfg_wdata_i
// Reclaim walks the pending entries through the single read port of the pending
// memories. After reset an init pass fills the free stack; till it ends, items
// are taken only into the command queue.
// A two-entry command queue lets commands arrive while results stall.
`timescale 1ns / 1ps
`default_nettype none
module fence_gated_slot_allocator_top #(
  parameter int unsigned PoolSlots = fgsa_pkg::PoolSlotsDefault
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [79:0]  s_axis_tdata,  // command, slot_index, fence
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [159:0]      m_axis_tdata,  // status, granted_slot, vtx_addr,
                                           // idx_addr, reclaimed_count, free_slots
  input  wire logic         cfg_we_i,
  input  wire logic [1:0]   cfg_idx_i,
  input  wire logic [63:0]  cfg_wdata_i
);
  logic [63:0] base_q;
  logic [31:0] vblk_q, iblk_q;
  logic qv, qr;
  fgsa_pkg::cmd_t qc;
  fgsa_pkg::res_t r;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0; vblk_q <= '0; iblk_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        fgsa_pkg::RegBase:   base_q <= cfg_wdata_i;
        fgsa_pkg::RegVertex: vblk_q <= cfg_wdata_i[31:0];
        fgsa_pkg::RegIndex:  iblk_q <= cfg_wdata_i[31:0];
        default: ;
      endcase
    end
  end

  fgsa_front #(.PoolSlots(PoolSlots)) u_front (
    .clk_i, .rst_ni, .valid_i(s_axis_tvalid), .ready_o(s_axis_tready),
    .command_i(s_axis_tdata[1:0]), .slot_index_i(s_axis_tdata[11:2]),
    .fence_i(s_axis_tdata[75:12]), .valid_o(qv), .ready_i(qr), .cmd_o(qc));

  fgsa_back #(.PoolSlots(PoolSlots)) u_back (
    .clk_i, .rst_ni, .valid_i(qv), .ready_o(qr), .cmd_i(qc),
    .base_i(base_q), .vblk_i(vblk_q), .iblk_i(iblk_q),
    .valid_o(m_axis_tvalid), .ready_i(m_axis_tready), .res_o(r));

  assign m_axis_tdata = {4'd0, r.free_slots, r.reclaimed_count, r.idx_addr,
                         r.vtx_addr, r.granted_slot, r.status};
endmodule
`default_nettype wire

[tb/fence_gated_slot_allocator_checker.sv]
`timescale 1ns / 1ps
module fence_gated_slot_allocator_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [79:0]  s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [159:0] m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [63:0]  cfg_wdata_i,
  output int           fail_count_o,
  output int           results_due_o,
  output int           free_count_o,
  output int           pending_count_o,
  output int           results_seen_o
);
  localparam int Slots = 256;

  logic [63:0]    base_q;
  logic [31:0]    vblk_bytes_q;
  logic [31:0]    iblk_bytes_q;
  logic [7:0]     free_stack_q [Slots];
  int             free_depth_q;
  logic [7:0]     pend_slot_q [Slots];
  logic [63:0]    pend_fence_q [Slots];
  int             pend_depth_q;
  fgsa_pkg::res_t results_due_q [$];

  assign results_due_o   = results_due_q.size();
  assign free_count_o    = free_depth_q;
  assign pending_count_o = pend_depth_q;

  function automatic logic [63:0] round_up_256(logic [31:0] bytes);
    logic [63:0] b;
    b = {32'd0, bytes} + 64'd255;
    return b & ~64'd255;
  endfunction

  function automatic fgsa_pkg::res_t allocate_step(logic [1:0] cmd, logic [9:0] slot,
                                                   logic [63:0] fence);
    fgsa_pkg::res_t r;
    int w;
    logic [63:0] vblk;
    logic [63:0] stride;
    r = '0;
    case (cmd)
      fgsa_pkg::CmdAcquire: begin
        if (free_depth_q == 0) begin
          r.status = fgsa_pkg::StExhaust;
        end else begin
          free_depth_q--;
          r.granted_slot = free_stack_q[free_depth_q];
        end
      end
      fgsa_pkg::CmdRelease: begin
        if (slot >= Slots) begin
          r.status = fgsa_pkg::StBadIndex;
        end else if (pend_depth_q >= Slots) begin
          r.status = fgsa_pkg::StPendFull;
        end else begin
          pend_slot_q[pend_depth_q] = slot[7:0];
          pend_fence_q[pend_depth_q] = fence;
          pend_depth_q++;
        end
      end
      fgsa_pkg::CmdReclaim: begin
        w = 0;
        for (int k = 0; k < pend_depth_q; k++) begin
          if (pend_fence_q[k] <= fence) begin
            if (free_depth_q < Slots) begin
              free_stack_q[free_depth_q] = pend_slot_q[k];
              free_depth_q++;
              r.reclaimed_count++;
            end
          end else begin
            pend_slot_q[w] = pend_slot_q[k];
            pend_fence_q[w] = pend_fence_q[k];
            w++;
          end
        end
        pend_depth_q = w;
      end
      default: begin
        if (slot >= Slots) begin
          r.status = fgsa_pkg::StBadIndex;
        end else begin
          vblk = round_up_256(vblk_bytes_q);
          stride = vblk + round_up_256(iblk_bytes_q);
          r.vtx_addr = base_q + 64'(slot) * stride;
          r.idx_addr = r.vtx_addr + vblk;
        end
      end
    endcase
    r.free_slots = 9'(free_depth_q);
    return r;
  endfunction

  function automatic fgsa_pkg::res_t unpack_result(logic [159:0] d);
    fgsa_pkg::res_t r;
    r.status          = d[1:0];
    r.granted_slot    = d[9:2];
    r.vtx_addr        = d[73:10];
    r.idx_addr        = d[137:74];
    r.reclaimed_count = d[146:138];
    r.free_slots      = d[155:147];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    fgsa_pkg::res_t got;
    fgsa_pkg::res_t want;
    fgsa_pkg::res_t pred;
    if (!rst_ni) begin
      base_q <= '0;
      vblk_bytes_q <= '0;
      iblk_bytes_q <= '0;
      for (int k = 0; k < Slots; k++) free_stack_q[k] = 8'(Slots - 1 - k);
      free_depth_q = Slots;
      pend_depth_q = 0;
      results_due_q.delete();
      fail_count_o <= 0;
      results_seen_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          fgsa_pkg::RegBase:   base_q <= cfg_wdata_i;
          fgsa_pkg::RegVertex: vblk_bytes_q <= cfg_wdata_i[31:0];
          fgsa_pkg::RegIndex:  iblk_bytes_q <= cfg_wdata_i[31:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        pred = allocate_step(s_axis_tdata[1:0], s_axis_tdata[11:2], s_axis_tdata[75:12]);
        results_due_q.insert(results_due_q.size(), pred);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = unpack_result(m_axis_tdata);
        results_seen_o <= results_seen_o + 1;
        if (results_due_q.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected result %p", got);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = results_due_q.pop_front();
          if (got !== want) begin
            if (fail_count_o < 10) $display("expected %p\n  actual %p", want, got);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end
endmodule

[tb/fence_gated_slot_allocator_top_test.sv]
`timescale 1ns / 1ps
module fence_gated_slot_allocator_top_test;
  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [79:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [159:0] m_axis_tdata;
  logic         cfg_we_i = 1'b0;
  logic [1:0]   cfg_idx_i = '0;
  logic [63:0]  cfg_wdata_i = '0;

  int fail_count;
  int results_due;
  int free_count;
  int pending_count;
  int results_seen;
  int items_sent;
  bit sink_hold;
  bit sink_steady;
  bit drive_steady;
  logic [63:0] last_fence;

  fence_gated_slot_allocator_top u_top (.*);

  fence_gated_slot_allocator_checker u_check (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .fail_count_o(fail_count), .results_due_o(results_due),
    .free_count_o(free_count), .pending_count_o(pending_count),
    .results_seen_o(results_seen)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50_000_000;
    $display("timeout");
    $display("fence_gated_slot_allocator_top: mismatch");
    $finish;
  end

  always @(negedge clk_i) begin
    if (sink_hold) m_axis_tready <= 1'b0;
    else if (sink_steady) m_axis_tready <= 1'b1;
    else m_axis_tready <= ($urandom_range(99) >= 16);
  end

  task automatic send_item(logic [1:0] cmd, logic [9:0] slot, logic [63:0] fence);
    while (!drive_steady && $urandom_range(99) < 16) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'd0, fence, slot, cmd};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (results_due != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_layout(logic [63:0] base, logic [31:0] vb, logic [31:0] ib);
    drain_results();
    write_reg(fgsa_pkg::RegBase, base);
    write_reg(fgsa_pkg::RegVertex, {32'd0, vb});
    write_reg(fgsa_pkg::RegIndex, {32'd0, ib});
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic random_item();
    int pick;
    logic [9:0] slot;
    pick = $urandom_range(99);
    slot = ($urandom_range(19) == 0) ? 10'($urandom_range(1023, 256))
                                     : 10'($urandom_range(255));
    if (pick < 30) begin
      send_item(fgsa_pkg::CmdAcquire, '0, rand64());
    end else if (pick < 65) begin
      last_fence = last_fence + 64'($urandom_range(5));
      send_item(fgsa_pkg::CmdRelease, slot,
                ($urandom_range(29) == 0) ? rand64() : last_fence);
    end else if (pick < 80) begin
      send_item(fgsa_pkg::CmdReclaim, slot,
                ($urandom_range(9) == 0) ? rand64() : last_fence - 64'($urandom_range(8)));
    end else begin
      send_item(fgsa_pkg::CmdQuery, slot, rand64());
    end
  endtask

  initial begin
    sink_hold = 0;
    sink_steady = 0;
    drive_steady = 0;
    items_sent = 0;
    last_fence = 64'd100;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    write_reg(fgsa_pkg::RegBase, 64'h1000);
    write_reg(fgsa_pkg::RegVertex, 64'd1);
    write_reg(fgsa_pkg::RegIndex, 64'd300);

    send_item(fgsa_pkg::CmdQuery, 10'd0, '0);
    send_item(fgsa_pkg::CmdQuery, 10'd255, '1);
    send_item(fgsa_pkg::CmdQuery, 10'd256, '0);
    send_item(fgsa_pkg::CmdQuery, 10'd1023, '0);
    send_item(fgsa_pkg::CmdReclaim, 10'd0, '1);
    send_item(fgsa_pkg::CmdAcquire, 10'd0, '0);
    send_item(fgsa_pkg::CmdAcquire, 10'd1023, '1);
    send_item(fgsa_pkg::CmdRelease, 10'd0, '1);
    send_item(fgsa_pkg::CmdRelease, 10'd1, 64'd0);
    send_item(fgsa_pkg::CmdRelease, 10'd1, 64'd5);
    send_item(fgsa_pkg::CmdRelease, 10'd1023, 64'd5);
    send_item(fgsa_pkg::CmdRelease, 10'd256, 64'd5);
    send_item(fgsa_pkg::CmdReclaim, 10'd0, 64'd4);
    send_item(fgsa_pkg::CmdReclaim, 10'd0, 64'd5);
    send_item(fgsa_pkg::CmdReclaim, 10'd0, '0);
    send_item(fgsa_pkg::CmdReclaim, 10'd0, '1);
    set_layout('1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(fgsa_pkg::CmdQuery, 10'd255, '0);
    send_item(fgsa_pkg::CmdQuery, 10'd1, '0);
    set_layout('0, 32'd0, 32'd0);
    send_item(fgsa_pkg::CmdQuery, 10'd200, '0);

    // exhaust the pool, fill the pending list to full, then reclaim
    drive_steady = 1;
    while (free_count > 0) send_item(fgsa_pkg::CmdAcquire, '0, '0);
    send_item(fgsa_pkg::CmdAcquire, '0, '0);
    for (int k = 0; k < 258; k++) send_item(fgsa_pkg::CmdRelease, 10'(k), 64'(k));
    send_item(fgsa_pkg::CmdReclaim, '0, 64'd99);
    send_item(fgsa_pkg::CmdRelease, 10'd3, 64'd0);
    send_item(fgsa_pkg::CmdReclaim, '0, '1);
    drive_steady = 0;

    // sink stalls while items keep coming
    sink_hold = 1;
    fork
      begin
        repeat (400) @(negedge clk_i);
        sink_hold = 0;
      end
      for (int k = 0; k < 20; k++) random_item();
    join
    drain_results();

    for (int k = 0; k < 1400; k++) begin
      if (k == 300) set_layout(rand64(), $urandom(), $urandom());
      if (k == 700) set_layout(64'h8000_0000_0000_0000, 32'd256, 32'd257);
      if (k == 900) begin
        sink_steady = 1;
        drive_steady = 1;
      end
      if (k == 1100) begin
        sink_steady = 0;
        drive_steady = 0;
      end
      if (k == 1300 && pending_count > 0) send_item(fgsa_pkg::CmdReclaim, '0, '1);
      random_item();
    end
    drain_results();

    $display("sent %0d items (acquire, release, reclaim, query), %0d results checked",
             items_sent, results_seen);
    $display("covered pool exhaustion, full pending list, bad indexes, layouts at extremes");
    if (fail_count == 0) begin
      $display("fence_gated_slot_allocator_top: match");
    end else begin
      $display("fence_gated_slot_allocator_top: mismatch");
    end
    $finish;
  end
endmodule
